[rtl/tgad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgad_pkg
// Types and constants shared by the TGA byte stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

    // Decoder phases, one-hot.
    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_HDR  = 6'b000010,
        PH_RAW  = 6'b000100,
        PH_PKT  = 6'b001000,
        PH_PIX  = 6'b010000,
        PH_HALT = 6'b100000
    } phase_t;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // Pixel format codes.
    localparam logic [1:0] FMT_MONO = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_RGBA = 2'd2;

    // Signature and header layout.
    localparam logic [3:0] SIG_TYPE_IDX = 4'd2;
    localparam logic [3:0] SIG_LEN      = 4'd12;
    localparam logic [3:0] HDR_WIDTH_LO  = 4'd0;
    localparam logic [3:0] HDR_WIDTH_HI  = 4'd1;
    localparam logic [3:0] HDR_HEIGHT_LO = 4'd2;
    localparam logic [3:0] HDR_HEIGHT_HI = 4'd3;
    localparam logic [3:0] HDR_DEPTH     = 4'd4;

    // Image type codes.
    localparam logic [7:0] TYPE_RAW_COLOR = 8'd2;
    localparam logic [7:0] TYPE_RAW_MONO  = 8'd3;
    localparam logic [7:0] TYPE_RLE_COLOR = 8'd10;
    localparam logic [7:0] TYPE_RLE_MONO  = 8'd11;

    // Depths in bits per pixel.
    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // Bytes per pixel codes; zero means unknown or unsupported.
    localparam logic [2:0] BPP_NONE = 3'd0;
    localparam logic [2:0] BPP_1    = 3'd1;
    localparam logic [2:0] BPP_3    = 3'd3;
    localparam logic [2:0] BPP_4    = 3'd4;

    // Packet headers at or above this value are run packets.
    localparam logic [7:0] PKT_RUN_FLAG = 8'd128;
    localparam logic [7:0] PKT_RUN_BIAS = 8'd127;

    function automatic logic [1:0] fmt_of(input logic [2:0] bpp);
        logic [1:0] f;
        begin
            f = FMT_MONO;
            if (bpp == BPP_3)
            begin
                f = FMT_RGB;
            end
            else if (bpp == BPP_4)
            begin
                f = FMT_RGBA;
            end
            return f;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/tga_image_stream_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// Decodes a TGA file arriving one byte per item into pixel runs with status.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register; its result is then
// registered in the result register and presented on the master side.
// Throughput: one byte per cycle while the master side is ready; the single
// pass of decode logic between the two registers sets this.
// Reset: rst_n clears the decoder state, the input register and the result
// valid flag; the decoder also returns to its reset state after every byte
// marked with tlast.
module tga_image_stream_decoder
    import tgad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // end_of_file
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte0, out_byte1, out_byte2, out_byte3, run_length,
    // image_width, image_height
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // image_done
    output logic [4:0]       m_axis_tuser    // pixel_format, status
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       advance;

    // Decoder state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic        comp_reg, comp_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [2:0]  bpp_reg, bpp_next;
    logic [31:0] pleft_reg, pleft_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [7:0]  cb_reg [4];
    logic [7:0]  cb_next [4];
    logic [1:0]  cidx_reg, cidx_next;

    // Result of the current item.
    logic        res_have;
    logic [7:0]  res_b0, res_b1, res_b2, res_b3, res_run;
    logic [1:0]  res_fmt;
    logic [15:0] res_width, res_height;
    logic        res_done;
    logic [2:0]  res_status;

    // Result register.
    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    logic        out_last_reg;
    logic [4:0]  out_user_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        logic        ok;
        logic        err;
        logic [2:0]  err_code;
        logic [7:0]  b;
        logic [7:0]  cnt;
        logic [31:0] area;
        logic [7:0]  run;
        logic [7:0]  left_dec;

        b        = in_byte_reg;
        err      = 1'b0;
        err_code = ST_OK;
        ok       = 1'b1;
        cnt      = '0;
        run      = 8'd1;
        left_dec = '0;
        area     = {16'd0, width_reg} * {16'd0, height_reg};

        phase_next    = phase_reg;
        hidx_next     = hidx_reg;
        comp_next     = comp_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        bpp_next      = bpp_reg;
        pleft_next    = pleft_reg;
        pkt_run_next  = pkt_run_reg;
        pkt_left_next = pkt_left_reg;
        for (int i = 0; i < 4; i++)
        begin
            cb_next[i] = cb_reg[i];
        end
        cidx_next = cidx_reg;

        res_have   = 1'b0;
        res_b0     = '0;
        res_b1     = '0;
        res_b2     = '0;
        res_b3     = '0;
        res_run    = '0;
        res_done   = 1'b0;
        res_status = ST_OK;

        case (phase_reg)
            PH_SIG:
            begin
                if (hidx_reg == SIG_TYPE_IDX)
                begin
                    ok = (b == TYPE_RAW_COLOR) || (b == TYPE_RAW_MONO) ||
                         (b == TYPE_RLE_COLOR) || (b == TYPE_RLE_MONO);
                    comp_next = (b >= TYPE_RLE_COLOR);
                end
                else
                begin
                    ok = (b == 8'd0);
                end
                if (!ok)
                begin
                    err      = 1'b1;
                    err_code = ST_BAD_SIG;
                end
                else
                begin
                    hidx_next = hidx_reg + 4'd1;
                    if (hidx_next >= SIG_LEN)
                    begin
                        phase_next = PH_HDR;
                        hidx_next  = '0;
                    end
                end
            end
            PH_HDR:
            begin
                case (hidx_reg)
                    HDR_WIDTH_LO:  width_next  = {8'd0, b};
                    HDR_WIDTH_HI:  width_next  = {b, width_reg[7:0]};
                    HDR_HEIGHT_LO: height_next = {8'd0, b};
                    HDR_HEIGHT_HI: height_next = {b, height_reg[7:0]};
                    HDR_DEPTH:
                    begin
                        if (b == DEPTH_24)
                        begin
                            bpp_next = BPP_3;
                        end
                        else if (b == DEPTH_32)
                        begin
                            bpp_next = BPP_4;
                        end
                        else if (b == DEPTH_8 && !comp_reg)
                        begin
                            bpp_next = BPP_1;
                        end
                        else
                        begin
                            bpp_next = BPP_NONE;
                        end
                    end
                    default:
                    begin
                        // The descriptor byte closes the header; checks happen here.
                        if (width_reg == 16'd0 || height_reg == 16'd0)
                        begin
                            err      = 1'b1;
                            err_code = ST_ZERO_SIZE;
                        end
                        else if (bpp_reg == BPP_NONE)
                        begin
                            err      = 1'b1;
                            err_code = ST_BAD_DEPTH;
                        end
                        else
                        begin
                            pleft_next = area;
                            cidx_next  = '0;
                            phase_next = comp_reg ? PH_PKT : PH_RAW;
                        end
                    end
                endcase
                hidx_next = hidx_reg + 4'd1;
            end
            PH_PKT:
            begin
                if (b < PKT_RUN_FLAG)
                begin
                    pkt_run_next = 1'b0;
                    cnt          = b + 8'd1;
                end
                else
                begin
                    pkt_run_next = 1'b1;
                    cnt          = b - PKT_RUN_BIAS;
                end
                if ({24'd0, cnt} > pleft_reg)
                begin
                    err      = 1'b1;
                    err_code = ST_OVERRUN;
                end
                else
                begin
                    pkt_left_next = cnt;
                    cidx_next     = '0;
                    phase_next    = PH_PIX;
                end
            end
            PH_RAW, PH_PIX:
            begin
                cb_next[cidx_reg] = b;
                if ({1'b0, cidx_reg} + 3'd1 >= bpp_reg)
                begin
                    cidx_next = '0;
                    if (phase_reg == PH_PIX && pkt_run_reg)
                    begin
                        run = pkt_left_reg;
                    end
                    if (bpp_reg == BPP_1)
                    begin
                        res_b0 = cb_next[0];
                    end
                    else
                    begin
                        // File order is blue, green, red.
                        res_b0 = cb_next[2];
                        res_b1 = cb_next[1];
                        res_b2 = cb_next[0];
                        res_b3 = (bpp_reg == BPP_4) ? cb_next[3] : 8'd0;
                    end
                    res_run  = run;
                    res_have = 1'b1;
                    pleft_next = ({24'd0, run} > pleft_reg) ? 32'd0
                                                            : pleft_reg - {24'd0, run};
                    if (phase_reg == PH_PIX)
                    begin
                        left_dec      = pkt_left_reg - 8'd1;
                        pkt_left_next = pkt_run_reg ? 8'd0 : left_dec;
                        if (pkt_left_next == 8'd0)
                        begin
                            phase_next = PH_PKT;
                        end
                    end
                    if (pleft_next == 32'd0)
                    begin
                        res_done   = 1'b1;
                        phase_next = PH_HALT;
                    end
                end
                else
                begin
                    cidx_next = cidx_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (err)
        begin
            res_have   = 1'b1;
            res_status = err_code;
            phase_next = PH_HALT;
        end

        res_fmt    = fmt_of(bpp_next);
        res_width  = width_next;
        res_height = height_next;

        if (in_eof_reg)
        begin
            // End of file before the image is complete counts as truncation.
            if (phase_next != PH_HALT)
            begin
                res_have   = 1'b1;
                res_status = ST_TRUNC;
            end
            phase_next    = PH_SIG;
            hidx_next     = '0;
            comp_next     = 1'b0;
            width_next    = '0;
            height_next   = '0;
            bpp_next      = BPP_NONE;
            pleft_next    = '0;
            pkt_run_next  = 1'b0;
            pkt_left_next = '0;
            for (int i = 0; i < 4; i++)
            begin
                cb_next[i] = '0;
            end
            cidx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
            in_eof_reg   <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
            in_byte_reg  <= s_axis_tdata;
            in_eof_reg   <= s_axis_tlast;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG;
            hidx_reg     <= '0;
            comp_reg     <= 1'b0;
            width_reg    <= '0;
            height_reg   <= '0;
            bpp_reg      <= BPP_NONE;
            pleft_reg    <= '0;
            pkt_run_reg  <= 1'b0;
            pkt_left_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                cb_reg[i] <= '0;
            end
            cidx_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            hidx_reg     <= hidx_next;
            comp_reg     <= comp_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            bpp_reg      <= bpp_next;
            pleft_reg    <= pleft_next;
            pkt_run_reg  <= pkt_run_next;
            pkt_left_reg <= pkt_left_next;
            for (int i = 0; i < 4; i++)
            begin
                cb_reg[i] <= cb_next[i];
            end
            cidx_reg <= cidx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_have;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_have)
        begin
            out_data_reg <= {res_height, res_width, res_run, res_b3, res_b2, res_b1, res_b0};
            out_last_reg <= res_done;
            out_user_reg <= {res_status, res_fmt};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    // A completed image result always has a nonzero run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[39:32] != 8'd0)
        else $error("completed image result with zero run length");

    // The decoder is back in its reset state after a byte marked end of file.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eof_reg |=> phase_reg == PH_SIG && hidx_reg == 4'd0 &&
                                  pleft_reg == 32'd0)
        else $error("decoder not restarted after end of file");

    // Pixel phases only run with a supported depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RAW || phase_reg == PH_PIX || phase_reg == PH_PKT
        |-> bpp_reg != BPP_NONE && pleft_reg != 32'd0)
        else $error("pixel phase without depth or remaining pixels");

    // A completed image result is never an error other than truncation.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast
        |-> m_axis_tuser[4:2] == ST_OK || m_axis_tuser[4:2] == ST_TRUNC)
        else $error("completed image result carries an error status");

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams TGA files into the decoder, byte by byte. A short table of directed
// items comes first. Random files follow: mostly well-formed raw and
// run-length images with random content, mixed with noise, broken signatures,
// bad headers, overruns and cut-off files. Every pixel run that comes out is
// compared field by field with the directed table or a behavioral decoder.
// ----------------------------------------------------------------------------
module testbench;
    import tgad_pkg::*;

    localparam int N_ITEMS    = 450;
    localparam int CALM_AFTER = 380;
    localparam int MAX_CYCLES = 300000;

    typedef struct packed {
        logic [7:0]  px0;
        logic [7:0]  px1;
        logic [7:0]  px2;
        logic [7:0]  px3;
        logic [7:0]  run_len;
        logic [1:0]  fmt;
        logic [15:0] width;
        logic [15:0] height;
        logic        done;
        logic [2:0]  status;
    } pixel_run_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        pixel_run_t exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [4:0]  m_axis_tuser;

    // Decoder model state.
    phase_t      dec_phase;
    logic [3:0]  hdr_idx;
    logic        rle;
    logic [15:0] w_reg;
    logic [15:0] h_reg;
    logic [2:0]  bpp;
    logic [31:0] px_left;
    logic        pkt_run;
    logic [7:0]  pkt_left;
    logic [7:0]  col [4];
    logic [1:0]  col_idx;

    pixel_run_t  expected_runs [$];
    stim_row_t   dir_rows [$];
    logic [8:0]  file_q [$];
    int          mismatch_count = 0;
    int          live_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    logic        calm;

    assign calm = (live_count >= CALM_AFTER);

    tga_image_stream_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [1:0] format_of(input logic [2:0] n);
        logic [1:0] f;
        begin
            f = FMT_MONO;
            if (n == BPP_3)
            begin
                f = FMT_RGB;
            end
            else if (n == BPP_4)
            begin
                f = FMT_RGBA;
            end
            return f;
        end
    endfunction

    function automatic pixel_run_t mk_run(input logic [7:0] p0, input logic [7:0] p1,
                                          input logic [7:0] p2, input logic [7:0] p3,
                                          input logic [7:0] rl, input logic [1:0] f,
                                          input logic [15:0] wd, input logic [15:0] ht,
                                          input logic dn, input logic [2:0] st);
        pixel_run_t r;
        begin
            r.px0 = p0;
            r.px1 = p1;
            r.px2 = p2;
            r.px3 = p3;
            r.run_len = rl;
            r.fmt = f;
            r.width = wd;
            r.height = ht;
            r.done = dn;
            r.status = st;
            return r;
        end
    endfunction

    task automatic decoder_reset();
        dec_phase = PH_SIG;
        hdr_idx = 4'd0;
        rle = 1'b0;
        w_reg = 16'd0;
        h_reg = 16'd0;
        bpp = BPP_NONE;
        px_left = 32'd0;
        pkt_run = 1'b0;
        pkt_left = 8'd0;
        col_idx = 2'd0;
        for (int k = 0; k < 4; k++)
        begin
            col[k] = 8'd0;
        end
    endtask

    // An error leaves only the status and what is known of the header.
    task automatic fail_image(inout pixel_run_t r, input logic [2:0] code);
        r = '0;
        r.fmt = format_of(bpp);
        r.width = w_reg;
        r.height = h_reg;
        r.status = code;
        dec_phase = PH_HALT;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eof,
                               output logic have, output pixel_run_t r);
        logic        ok;
        logic [31:0] cnt;
        logic [31:0] run;
        have = 1'b0;
        r = '0;
        case (dec_phase)
            PH_SIG:
            begin
                if (hdr_idx == SIG_TYPE_IDX)
                begin
                    ok = (b == TYPE_RAW_COLOR) || (b == TYPE_RAW_MONO) ||
                         (b == TYPE_RLE_COLOR) || (b == TYPE_RLE_MONO);
                    rle = (b >= TYPE_RLE_COLOR);
                end
                else
                begin
                    ok = (b == 8'd0);
                end
                if (!ok)
                begin
                    fail_image(r, ST_BAD_SIG);
                    have = 1'b1;
                end
                else
                begin
                    hdr_idx = hdr_idx + 4'd1;
                    if (hdr_idx >= SIG_LEN)
                    begin
                        dec_phase = PH_HDR;
                        hdr_idx = 4'd0;
                    end
                end
            end
            PH_HDR:
            begin
                case (hdr_idx)
                    HDR_WIDTH_LO:  w_reg = {8'd0, b};
                    HDR_WIDTH_HI:  w_reg[15:8] = b;
                    HDR_HEIGHT_LO: h_reg = {8'd0, b};
                    HDR_HEIGHT_HI: h_reg[15:8] = b;
                    HDR_DEPTH:
                    begin
                        if (b == DEPTH_24)
                        begin
                            bpp = BPP_3;
                        end
                        else if (b == DEPTH_32)
                        begin
                            bpp = BPP_4;
                        end
                        else if (b == DEPTH_8 && !rle)
                        begin
                            bpp = BPP_1;
                        end
                        else
                        begin
                            bpp = BPP_NONE;
                        end
                    end
                    default:
                    begin
                        // The descriptor byte triggers the header checks.
                        if (w_reg == 16'd0 || h_reg == 16'd0)
                        begin
                            fail_image(r, ST_ZERO_SIZE);
                            have = 1'b1;
                        end
                        else if (bpp == BPP_NONE)
                        begin
                            fail_image(r, ST_BAD_DEPTH);
                            have = 1'b1;
                        end
                        else
                        begin
                            px_left = {16'd0, w_reg} * {16'd0, h_reg};
                            col_idx = 2'd0;
                            dec_phase = rle ? PH_PKT : PH_RAW;
                        end
                    end
                endcase
                hdr_idx = hdr_idx + 4'd1;
            end
            PH_PKT:
            begin
                if (b < PKT_RUN_FLAG)
                begin
                    pkt_run = 1'b0;
                    cnt = {24'd0, b} + 32'd1;
                end
                else
                begin
                    pkt_run = 1'b1;
                    cnt = {24'd0, b} - {24'd0, PKT_RUN_BIAS};
                end
                if (cnt > px_left)
                begin
                    fail_image(r, ST_OVERRUN);
                    have = 1'b1;
                end
                else
                begin
                    pkt_left = cnt[7:0];
                    col_idx = 2'd0;
                    dec_phase = PH_PIX;
                end
            end
            PH_RAW, PH_PIX:
            begin
                col[col_idx] = b;
                if ({30'd0, col_idx} + 32'd1 >= {29'd0, bpp})
                begin
                    run = 32'd1;
                    col_idx = 2'd0;
                    if (dec_phase == PH_PIX && pkt_run)
                    begin
                        run = {24'd0, pkt_left};
                    end
                    if (bpp == BPP_1)
                    begin
                        r.px0 = col[0];
                    end
                    else
                    begin
                        // Stored order is blue, green, red.
                        r.px0 = col[2];
                        r.px1 = col[1];
                        r.px2 = col[0];
                        r.px3 = (bpp == BPP_4) ? col[3] : 8'd0;
                    end
                    r.run_len = run[7:0];
                    r.fmt = format_of(bpp);
                    r.width = w_reg;
                    r.height = h_reg;
                    have = 1'b1;
                    px_left = (run > px_left) ? 32'd0 : px_left - run;
                    if (dec_phase == PH_PIX)
                    begin
                        pkt_left = pkt_run ? 8'd0 : pkt_left - 8'd1;
                        if (pkt_left == 8'd0)
                        begin
                            dec_phase = PH_PKT;
                        end
                    end
                    if (px_left == 32'd0)
                    begin
                        r.done = 1'b1;
                        dec_phase = PH_HALT;
                    end
                end
                else
                begin
                    col_idx = col_idx + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (eof)
        begin
            if (dec_phase != PH_HALT)
            begin
                if (have)
                begin
                    r.status = ST_TRUNC;
                end
                else
                begin
                    fail_image(r, ST_TRUNC);
                    have = 1'b1;
                end
            end
            decoder_reset();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got_v, exp_v);
        mismatch_count++;
    endtask

    task automatic check_run(input pixel_run_t got);
        pixel_run_t e;
        if (expected_runs.size() == 0)
        begin
            report_mismatch("unexpected result", 32'(got.status), 32'd0);
        end
        else
        begin
            e = expected_runs.pop_front();
            if (got.px0 !== e.px0)
                report_mismatch("out_byte0", 32'(got.px0), 32'(e.px0));
            if (got.px1 !== e.px1)
                report_mismatch("out_byte1", 32'(got.px1), 32'(e.px1));
            if (got.px2 !== e.px2)
                report_mismatch("out_byte2", 32'(got.px2), 32'(e.px2));
            if (got.px3 !== e.px3)
                report_mismatch("out_byte3", 32'(got.px3), 32'(e.px3));
            if (got.run_len !== e.run_len)
                report_mismatch("run_length", 32'(got.run_len), 32'(e.run_len));
            if (got.fmt !== e.fmt)
                report_mismatch("pixel_format", 32'(got.fmt), 32'(e.fmt));
            if (got.width !== e.width)
                report_mismatch("image_width", 32'(got.width), 32'(e.width));
            if (got.height !== e.height)
                report_mismatch("image_height", 32'(got.height), 32'(e.height));
            if (got.done !== e.done)
                report_mismatch("image_done", 32'(got.done), 32'(e.done));
            if (got.status !== e.status)
                report_mismatch("status", 32'(got.status), 32'(e.status));
        end
    endtask

    // Result side: random stall bursts until the run calms down.
    initial
    begin
        pixel_run_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.px0 = m_axis_tdata[7:0];
                got.px1 = m_axis_tdata[15:8];
                got.px2 = m_axis_tdata[23:16];
                got.px3 = m_axis_tdata[31:24];
                got.run_len = m_axis_tdata[39:32];
                got.width = m_axis_tdata[55:40];
                got.height = m_axis_tdata[71:56];
                got.fmt = m_axis_tuser[1:0];
                got.status = m_axis_tuser[4:2];
                got.done = m_axis_tlast;
                check_run(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                             input pixel_run_t typed_exp);
        logic       have;
        pixel_run_t res;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= l;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        // Bytes swallowed after an error do not count toward the item total.
        if (dec_phase != PH_HALT || l)
        begin
            live_count++;
        end
        decode_byte(d, l, have, res);
        if (typed)
        begin
            expected_runs.push_back(typed_exp);
        end
        else if (have)
        begin
            expected_runs.push_back(res);
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] d, input logic l, input logic typed,
                           input pixel_run_t e);
        stim_row_t row;
        row.data = d;
        row.last = l;
        row.typed = typed;
        row.exp = e;
        dir_rows.push_back(row);
    endtask

    task automatic push_random(input int n);
        repeat (n) file_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    endtask

    task automatic push_sig(input logic [7:0] ftype);
        for (int k = 0; k < 12; k++)
        begin
            file_q.push_back({1'b0, (k == SIG_TYPE_IDX) ? ftype : 8'd0});
        end
    endtask

    task automatic push_hdr(input logic [15:0] w, input logic [15:0] h, input logic [7:0] depth);
        file_q.push_back({1'b0, w[7:0]});
        file_q.push_back({1'b0, w[15:8]});
        file_q.push_back({1'b0, h[7:0]});
        file_q.push_back({1'b0, h[15:8]});
        file_q.push_back({1'b0, depth});
        push_random(1);
    endtask

    // Builds one random file in file_q, last byte marked as end of file.
    task automatic build_file();
        int          kind;
        int          nbytes;
        int          npix;
        int          left;
        int          cnt;
        int          pos;
        logic [7:0]  ftype;
        logic [7:0]  depth;
        logic [7:0]  b;
        logic [15:0] w;
        logic [15:0] h;
        logic        rle_img;
        logic [8:0]  tail;
        file_q.delete();
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: ftype = TYPE_RAW_COLOR;
            1: ftype = TYPE_RAW_MONO;
            2: ftype = TYPE_RLE_COLOR;
            default: ftype = TYPE_RLE_MONO;
        endcase
        rle_img = (ftype >= TYPE_RLE_COLOR);
        if (rle_img)
        begin
            depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: depth = DEPTH_8;
                1: depth = DEPTH_24;
                default: depth = DEPTH_32;
            endcase
        end
        nbytes = (depth == DEPTH_8) ? 1 : ((depth == DEPTH_24) ? 3 : 4);
        if (kind < 5)
        begin
            push_random($urandom_range(1, 16));
        end
        else if (kind < 12)
        begin
            // One signature byte goes wrong.
            push_sig(ftype);
            pos = $urandom_range(0, 11);
            if (pos == SIG_TYPE_IDX)
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                end
                while (b == TYPE_RAW_COLOR || b == TYPE_RAW_MONO ||
                       b == TYPE_RLE_COLOR || b == TYPE_RLE_MONO);
            end
            else
            begin
                b = 8'($urandom_range(1, 255));
            end
            file_q[pos] = {1'b0, b};
            push_random($urandom_range(0, 8));
        end
        else if (kind < 20)
        begin
            w = 16'($urandom_range(1, 3));
            h = 16'($urandom_range(1, 3));
            if ($urandom_range(0, 1))
            begin
                if ($urandom_range(0, 1))
                begin
                    w = 16'd0;
                end
                else
                begin
                    h = 16'd0;
                end
                depth = 8'($urandom_range(0, 255));
            end
            else if (rle_img && $urandom_range(0, 1))
            begin
                depth = DEPTH_8;
            end
            else
            begin
                do
                begin
                    depth = 8'($urandom_range(0, 255));
                end
                while (depth == DEPTH_8 || depth == DEPTH_24 || depth == DEPTH_32);
            end
            push_sig(ftype);
            push_hdr(w, h, depth);
            push_random($urandom_range(0, 6));
        end
        else if (kind < 26)
        begin
            // Image of random size, mostly very large, that is usually cut short.
            w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            h = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            push_sig(ftype);
            push_hdr(w, h, depth);
            push_random($urandom_range(0, 4 * nbytes + 1));
        end
        else
        begin
            w = 16'($urandom_range(1, 3));
            h = 16'($urandom_range(1, 3));
            if (rle_img && $urandom_range(0, 3) == 0)
            begin
                w = 16'd16;
                h = 16'($urandom_range(1, 8));
            end
            npix = int'(w) * int'(h);
            push_sig(ftype);
            push_hdr(w, h, depth);
            if (!rle_img)
            begin
                push_random(npix * nbytes);
            end
            else
            begin
                left = npix;
                while (left > 0)
                begin
                    if (left < 128 && $urandom_range(0, 15) == 0)
                    begin
                        // Packet longer than what is left of the image.
                        cnt = $urandom_range(left + 1, 128);
                        b = $urandom_range(0, 1) ? 8'(cnt - 1) : 8'(cnt + 127);
                        file_q.push_back({1'b0, b});
                        push_random($urandom_range(0, 2 * nbytes));
                        left = 0;
                    end
                    else
                    begin
                        cnt = $urandom_range(1, (left < 128) ? left : 128);
                        if ($urandom_range(0, 3) == 0)
                        begin
                            cnt = (left < 128) ? left : 128;
                        end
                        if (cnt > 4 || $urandom_range(0, 1))
                        begin
                            file_q.push_back({1'b0, 8'(cnt + 127)});
                            push_random(nbytes);
                        end
                        else
                        begin
                            file_q.push_back({1'b0, 8'(cnt - 1)});
                            push_random(cnt * nbytes);
                        end
                        left = left - cnt;
                    end
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                push_random($urandom_range(1, 4));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                pos = $urandom_range(1, file_q.size() - 1);
                while (file_q.size() > pos)
                begin
                    tail = file_q.pop_back();
                end
            end
        end
        tail = file_q.pop_back();
        tail[8] = 1'b1;
        file_q.push_back(tail);
    endtask

    initial
    begin
        stim_row_t row;
        int        i;
        decoder_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bad first byte, a byte ignored until end of file, then a one-byte file cut short.
        add_row(8'hFF, 1'b0, 1'b1,
                mk_run(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, FMT_MONO, 16'd0, 16'd0, 1'b0, ST_BAD_SIG));
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1,
                mk_run(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, FMT_MONO, 16'd0, 16'd0, 1'b0, ST_TRUNC));
        // One-pixel grayscale image whose last byte is also the end of file.
        for (i = 0; i < 12; i++)
        begin
            add_row((i == SIG_TYPE_IDX) ? TYPE_RAW_MONO : 8'd0, 1'b0, 1'b0, '0);
        end
        add_row(8'd1, 1'b0, 1'b0, '0);
        add_row(8'd0, 1'b0, 1'b0, '0);
        add_row(8'd1, 1'b0, 1'b0, '0);
        add_row(8'd0, 1'b0, 1'b0, '0);
        add_row(DEPTH_8, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1,
                mk_run(8'hFF, 8'd0, 8'd0, 8'd0, 8'd1, FMT_MONO, 16'd1, 16'd1, 1'b1, ST_OK));

        for (i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            send_byte(row.data, row.last, row.typed, row.exp);
        end
        hold_until_drained();

        while (live_count < N_ITEMS)
        begin
            build_file();
            if ($urandom_range(0, 9) == 0)
            begin
                hold_until_drained();
            end
            for (i = 0; i < file_q.size(); i++)
            begin
                send_byte(file_q[i][7:0], file_q[i][8], 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/tgad_pkg.sv
rtl/tga_image_stream_decoder.sv
sim/testbench.sv
